### src/assert_macros.svh
// assertion macros shared by the hex dump formatter
// a file that uses them has clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HDF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("hdf assertion failed");

`define HDF_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("hdf forbidden condition seen");

`else

`define HDF_ASSERT(lbl, prop)

`define HDF_ASSERT_NEVER(lbl, expr)

`endif

`endif

### src/hdf_pkg.sv
// ----------------------------------------------------------------------------
// hdf_pkg
// Types, character codes and lookup functions of the hex dump formatter.
// ----------------------------------------------------------------------------
package hdf_pkg;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;
	localparam int ADDR_W = 64;
	localparam int OFF_W  = 60;
	localparam int NIB_W  = 4;

	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_COLON = 7'h3a;
	localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2e;
	localparam logic [CHAR_W-1:0] CH_NL    = 7'h0a;

	localparam logic [BYTE_W-1:0] LAST_CTRL = 8'd31;
	localparam logic [BYTE_W-1:0] FIRST_DEL = 8'd127;

	localparam logic [CHAR_W-1:0] HEX_TABLE [16] = '{
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
		7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
	};

	typedef enum logic [2:0] {
		CK_HEX,
		CK_SPACE,
		CK_COLON,
		CK_BYTE,
		CK_NL
	} char_kind_t;

	typedef struct packed {
		logic              valid;
		char_kind_t        kind;
		logic [BYTE_W-1:0] operand;
		logic              last;
	} char_req_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] nib);
		return HEX_TABLE[nib];
	endfunction

	function automatic logic [CHAR_W-1:0] print_char(input logic [BYTE_W-1:0] b);
		logic [CHAR_W-1:0] c;
		if (b <= LAST_CTRL || b >= FIRST_DEL) begin
			c = CH_DOT;
		end else begin
			c = b[CHAR_W-1:0];
		end
		return c;
	endfunction

endpackage

### src/hdf_in_if.sv
// ----------------------------------------------------------------------------
// hdf_in_if
// Byte input channel: valid/ready handshake with data byte and end marker.
// ----------------------------------------------------------------------------
interface hdf_in_if;
	import hdf_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_dump;

	modport source (output valid, output data_byte, output end_of_dump, input ready);
	modport sink (input valid, input data_byte, input end_of_dump, output ready);
endinterface

### src/hdf_out_if.sv
// ----------------------------------------------------------------------------
// hdf_out_if
// Character output channel: valid/ready handshake with one ASCII character.
// ----------------------------------------------------------------------------
interface hdf_out_if;
	import hdf_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ascii_char;
	logic              last_char;

	modport source (output valid, output ascii_char, output last_char, input ready);
	modport sink (input valid, input ascii_char, input last_char, output ready);
endinterface

### src/hdf_char_unit.sv
// ----------------------------------------------------------------------------
// hdf_char_unit
// Shared character unit: maps each request to ASCII and holds it in the
// output register until the receiver takes it.
// ----------------------------------------------------------------------------
module hdf_char_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  hdf_pkg::char_req_t req,
	output logic               take,
	hdf_out_if.source          char_out
);
	import hdf_pkg::*;

	logic [CHAR_W-1:0] ch;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	always_comb begin
		unique case (req.kind)
			CK_HEX:   ch = hex_char(req.operand[NIB_W-1:0]);
			CK_SPACE: ch = CH_SPACE;
			CK_COLON: ch = CH_COLON;
			CK_BYTE:  ch = print_char(req.operand);
			CK_NL:    ch = CH_NL;
			default:  ch = CH_SPACE;
		endcase
	end

	// register free or being emptied this cycle
	assign take = !valid_q || char_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && req.valid) begin
			char_q <= ch;
			last_q <= req.last;
		end
	end

	assign char_out.valid      = valid_q;
	assign char_out.ascii_char = char_q;
	assign char_out.last_char  = last_q;
endmodule

### src/hdf_seq.sv
// ----------------------------------------------------------------------------
// hdf_seq
// Line sequencer: holds the line buffer and address state and steps the
// character unit through one dump line piece by piece.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdf_seq #(
	parameter int BPL = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hdf_pkg::ADDR_W-1:0] cfg_wdata,
	hdf_in_if.sink                     byte_in,
	input  logic                       take,
	output hdf_pkg::char_req_t         req
);
	import hdf_pkg::*;

	localparam int POS_W  = $clog2(BPL);
	localparam int PCNT_W = $clog2(BPL + 1);
	localparam int CNT_W  = (PCNT_W > NIB_W) ? PCNT_W : NIB_W;
	localparam int DIGITS = ADDR_W / NIB_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADDR,
		S_COLON,
		S_SEP,
		S_HI,
		S_LO,
		S_PAD,
		S_GAP,
		S_CHARS,
		S_NL
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   base_q;
	logic [ADDR_W-1:0]   step_q;
	logic [OFF_W-1:0]    off_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [BYTE_W-1:0]   byte_q;
	logic                end_q;
	logic [PCNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [1:0]          sub_q;
	logic [BYTE_W-1:0]   buf_q [BPL];

	logic                accept;
	logic [PCNT_W-1:0]   pos_inc;
	logic                close;
	logic [1:0]          pad_last;

	assign byte_in.ready = (state_q == S_IDLE);
	assign accept        = byte_in.valid && byte_in.ready;
	assign pos_inc       = pos_q + PCNT_W'(1);
	assign close         = end_q || (pos_inc == PCNT_W'(BPL));
	// even byte slots carry an extra separator space
	assign pad_last      = cnt_q[0] ? 2'd1 : 2'd2;

	always_comb begin
		req.valid   = (state_q != S_IDLE);
		req.kind    = CK_SPACE;
		req.operand = '0;
		req.last    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.valid = 1'b0;
			end
			S_ADDR: begin
				req.kind    = CK_HEX;
				req.operand = {{(BYTE_W-NIB_W){1'b0}}, addr_q[ADDR_W-1 -: NIB_W]};
			end
			S_COLON: req.kind = CK_COLON;
			S_SEP:   req.kind = CK_SPACE;
			S_HI: begin
				req.kind    = CK_HEX;
				req.operand = {{(BYTE_W-NIB_W){1'b0}}, byte_q[BYTE_W-1 -: NIB_W]};
			end
			S_LO: begin
				req.kind    = CK_HEX;
				req.operand = {{(BYTE_W-NIB_W){1'b0}}, byte_q[NIB_W-1:0]};
				req.last    = !close;
			end
			S_PAD:   req.kind = CK_SPACE;
			S_GAP:   req.kind = CK_SPACE;
			S_CHARS: begin
				req.kind    = CK_BYTE;
				req.operand = buf_q[cnt_q[POS_W-1:0]];
			end
			S_NL: begin
				req.kind = CK_NL;
				req.last = 1'b1;
			end
			default: req.valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q  <= '0;
			step_q  <= '0;
			off_q   <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			sub_q   <= '0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (pos_q == '0) begin
							state_q <= S_ADDR;
						end else if (!pos_q[0]) begin
							state_q <= S_SEP;
						end else begin
							state_q <= S_HI;
						end
					end
				end
				S_ADDR: begin
					if (take) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (cnt_q == CNT_W'(DIGITS - 1)) begin
							state_q <= S_COLON;
						end
					end
				end
				S_COLON: if (take) state_q <= S_SEP;
				S_SEP:   if (take) state_q <= S_HI;
				S_HI:    if (take) state_q <= S_LO;
				S_LO: begin
					if (take) begin
						pos_q <= pos_inc;
						if (!close) begin
							state_q <= S_IDLE;
						end else if (pos_inc < PCNT_W'(BPL)) begin
							state_q <= S_PAD;
							cnt_q   <= CNT_W'(pos_inc);
							sub_q   <= '0;
						end else begin
							state_q <= S_GAP;
						end
					end
				end
				S_PAD: begin
					if (take) begin
						if (sub_q == pad_last) begin
							sub_q <= '0;
							if (cnt_q == CNT_W'(BPL - 1)) begin
								state_q <= S_GAP;
							end else begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
						end else begin
							sub_q <= sub_q + 2'd1;
						end
					end
				end
				S_GAP: begin
					if (take) begin
						state_q <= S_CHARS;
						cnt_q   <= '0;
					end
				end
				S_CHARS: begin
					if (take) begin
						if (cnt_q == CNT_W'(pos_q) - CNT_W'(1)) begin
							state_q <= S_NL;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_NL: begin
					if (take) begin
						state_q <= S_IDLE;
						pos_q   <= '0;
						if (end_q) begin
							off_q  <= '0;
							step_q <= '0;
						end else begin
							off_q <= off_q + OFF_W'(1);
							// line number wraps, so its byte offset restarts too
							if (&off_q) begin
								step_q <= '0;
							end else begin
								step_q <= step_q + ADDR_W'(BPL);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q                   <= byte_in.data_byte;
			end_q                    <= byte_in.end_of_dump;
			addr_q                   <= base_q + step_q;
			buf_q[pos_q[POS_W-1:0]] <= byte_in.data_byte;
		end else if (state_q == S_ADDR && take) begin
			addr_q <= {addr_q[ADDR_W-NIB_W-1:0], {NIB_W{1'b0}}};
		end
	end

	`HDF_ASSERT(a_pos_in_line, (state_q == S_IDLE) |-> (pos_q < PCNT_W'(BPL)))
	`HDF_ASSERT(a_busy_after_accept, (byte_in.valid && byte_in.ready) |=> !byte_in.ready)
	`HDF_ASSERT(a_line_closed, (state_q == S_NL && take) |=> (pos_q == '0))
	`HDF_ASSERT(a_all_digits, (state_q == S_COLON) |-> (cnt_q == CNT_W'(DIGITS)))
	`HDF_ASSERT_NEVER(a_pad_range, state_q == S_PAD && cnt_q < CNT_W'(pos_q))
endmodule

### src/hex_dump_formatter_top.sv
// ----------------------------------------------------------------------------
// hex_dump_formatter_top
// Hex dump formatter: byte stream in, one ASCII text character per word out.
// ----------------------------------------------------------------------------
// byte_in takes one data byte per word plus end_of_dump, which closes the
// current line early and restarts the next dump at base_address. char_out
// gives one character per word; last_char flags the final character that
// a byte causes. base_address is written through cfg_we/cfg_wdata while
// the block is idle; the user is bound to this, the block does not enforce it.
// Each byte is accepted while the sequencer is idle and requests no character,
// and then causes its characters: 2 for a mid-line byte at an odd position, 3
// at an even one, 20 for the first byte of a line (address, colon, separator,
// hex pair) and up to 60 for a byte that closes a line (padding, character
// column, newline); a full line of 16 bytes is 75 characters. The shared
// character unit emits one character a cycle while the receiver does not stall.
// After acceptance the sequencer leaves idle and the first character is then
// registered in the output register.
// Reset clears the line position, line number and base address; the line
// buffer is not cleared. When the receiver stalls, the output register holds
// its character and the sequencer waits; byte_in stays not ready until the
// last character of the current byte is in the output register.
// ----------------------------------------------------------------------------
module hex_dump_formatter_top #(
	parameter int BYTES_PER_LINE = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [hdf_pkg::ADDR_W-1:0] cfg_wdata,
	hdf_in_if.sink                     byte_in,
	hdf_out_if.source                  char_out
);
	import hdf_pkg::*;

	char_req_t req;
	logic      take;

	hdf_seq #(
		.BPL(BYTES_PER_LINE)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.byte_in  (byte_in),
		.take     (take),
		.req      (req)
	);

	hdf_char_unit u_char (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.take    (take),
		.char_out(char_out)
	);
endmodule

### tb/hdf_dump_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdf_dump_checker
// Watches the byte and character channels of the hex dump formatter, builds
// the expected dump text for every accepted byte and compares each character
// word against it in order.
// ----------------------------------------------------------------------------
module hdf_dump_checker
	import hdf_pkg::*;
#(
	parameter int LINE_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_wdata,
	hdf_in_if                 byte_mon,
	hdf_out_if                char_mon,
	output int unsigned       fail_count,
	output int unsigned       pending
);

	localparam int FILL_W = $clog2(LINE_BYTES);

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} dump_char_t;

	dump_char_t        dump_text_q [$];
	logic [BYTE_W-1:0] line_buf [LINE_BYTES];
	logic [FILL_W-1:0] line_fill = '0;
	logic [OFF_W-1:0]  line_num  = '0;
	logic [ADDR_W-1:0] base_addr = '0;
	int unsigned       fails     = 0;
	int unsigned       queued    = 0;

	assign fail_count = fails;
	assign pending    = queued;

	function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] n);
		return (n < 4'd10) ? CHAR_W'(7'h30 + n) : CHAR_W'(7'h57 + n);
	endfunction

	function automatic logic [CHAR_W-1:0] shown_char(input logic [BYTE_W-1:0] b);
		return (b < 8'd32 || b > 8'd126) ? CH_DOT : b[CHAR_W-1:0];
	endfunction

	function automatic void put_char(input logic [CHAR_W-1:0] c);
		dump_text_q.push_back('{ch: c, last: 1'b0});
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		$display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		fails++;
	endtask

	// text caused by one byte: address prefix at line start, separator space at even
	// positions, hex pair, and padding, character column and newline when the line closes
	task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic eod);
		logic [ADDR_W-1:0] addr;
		int                s;
		int                p;
		int                fill;
		if (line_fill == 0) begin
			addr = base_addr + {line_num, 4'b0000};
			for (s = ADDR_W - 4; s >= 0; s -= 4) begin
				put_char(nibble_char(addr[s +: 4]));
			end
			put_char(CH_COLON);
		end
		if (!line_fill[0]) begin
			put_char(CH_SPACE);
		end
		put_char(nibble_char(b[7:4]));
		put_char(nibble_char(b[3:0]));
		line_buf[line_fill] = b;
		fill = int'(line_fill) + 1;
		if (eod || fill >= LINE_BYTES) begin
			for (p = fill; p < LINE_BYTES; p++) begin
				if (p % 2 == 0) begin
					put_char(CH_SPACE);
				end
				put_char(CH_SPACE);
				put_char(CH_SPACE);
			end
			put_char(CH_SPACE);
			for (p = 0; p < fill; p++) begin
				put_char(shown_char(line_buf[p]));
			end
			put_char(CH_NL);
			line_num  = eod ? '0 : line_num + 1'b1;
			line_fill = '0;
		end else begin
			line_fill = FILL_W'(fill);
		end
		dump_text_q[dump_text_q.size() - 1].last = 1'b1;
	endtask

	task automatic check_char(input logic [CHAR_W-1:0] c, input logic l);
		dump_char_t want;
		if (dump_text_q.size() == 0) begin
			report_mismatch("unexpected character word", 8'h00, {1'b0, c});
		end else begin
			want = dump_text_q.pop_front();
			if (c !== want.ch) begin
				report_mismatch("ascii_char", {1'b0, want.ch}, {1'b0, c});
			end
			if (l !== want.last) begin
				report_mismatch("last_char", {7'd0, want.last}, {7'd0, l});
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_fill = '0;
			line_num  = '0;
			base_addr = '0;
			dump_text_q.delete();
			queued <= 0;
		end else begin
			if (cfg_we) begin
				base_addr = cfg_wdata;
			end
			if (byte_mon.valid && byte_mon.ready) begin
				predict_byte(byte_mon.data_byte, byte_mon.end_of_dump);
			end
			if (char_mon.valid && char_mon.ready) begin
				check_char(char_mon.ascii_char, char_mon.last_char);
			end
			queued <= dump_text_q.size();
		end
	end

endmodule

### tb/hex_dump_formatter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_dump_formatter_top_test
// Drives byte streams through the hex dump formatter under several base
// addresses, with random gaps and receiver stalls, and lets the checker
// judge every character word.
// ----------------------------------------------------------------------------
module hex_dump_formatter_top_test;
	import hdf_pkg::*;

	localparam int LINE_BYTES = 16;
	localparam int LONG_HOLD  = 400;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [ADDR_W-1:0] cfg_wdata;
	int unsigned       fail_count;
	int unsigned       pending;
	bit                tx_idle_en;
	bit                rx_idle_en;
	bit                long_hold;
	int                rx_stall;
	int                phase;

	logic [BYTE_W-1:0] corner_bytes [16] = '{
		8'h00, 8'hff, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'h80, 8'h01,
		8'h41, 8'h5a, 8'h61, 8'h7a, 8'h30, 8'h39, 8'haa, 8'h55
	};

	hdf_in_if  byte_ch ();
	hdf_out_if char_ch ();

	hex_dump_formatter_top #(
		.BYTES_PER_LINE(LINE_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.byte_in  (byte_ch),
		.char_out (char_ch)
	);

	hdf_dump_checker #(
		.LINE_BYTES(LINE_BYTES)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_mon  (byte_ch),
		.char_mon  (char_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		char_ch.ready = 1'b0;
		rx_stall = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				char_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (rx_stall > 0) begin
				char_ch.ready <= 1'b0;
				rx_stall--;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				char_ch.ready <= 1'b0;
				rx_stall = $urandom_range(1, 9) - 1;
			end else begin
				char_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eod);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.data_byte   <= b;
		byte_ch.end_of_dump <= eod;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
	endtask

	// drop valid and wait until every expected character has been checked
	task automatic settle();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] random_byte();
		logic [BYTE_W-1:0] picks [4] = '{8'd31, 8'd32, 8'd126, 8'd127};
		return ($urandom_range(0, 3) == 0) ? picks[$urandom_range(0, 3)]
			: BYTE_W'($urandom_range(0, 255));
	endfunction

	// random dumps of mixed length; the last one may be left open
	task automatic send_dumps(input int budget);
		int len;
		int k;
		bit close_it;
		while (budget > 0) begin
			case ($urandom_range(0, 5))
				0: len = LINE_BYTES;
				1: len = 2 * LINE_BYTES;
				2: len = $urandom_range(1, 4);
				default: len = $urandom_range(1, 40);
			endcase
			close_it = 1'b1;
			if (len >= budget) begin
				len = budget;
				close_it = ($urandom_range(0, 3) != 0);
			end
			for (k = 0; k < len; k++) begin
				send_byte(random_byte(), close_it && k == len - 1);
			end
			budget -= len;
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = '0;
		byte_ch.end_of_dump = 1'b0;
		tx_idle_en          = 1'b1;
		rx_idle_en          = 1'b1;
		long_hold           = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-byte dump from the reset base
		send_byte(8'h00, 1'b1);
		settle();

		// full line of corner values, then a short line across the address wrap
		write_base('1);
		for (int i = 0; i < 16; i++) begin
			send_byte(corner_bytes[i], 1'b0);
		end
		send_byte(8'h41, 1'b0);
		send_byte(8'h7e, 1'b1);

		for (phase = 0; phase < 7; phase++) begin
			settle();
			case (phase)
				0: write_base(64'hffff_ffff_ffff_ff00);
				1: write_base('0);
				2: write_base(64'h8000_0000_0000_0000);
				default: write_base({$urandom, $urandom});
			endcase
			if (phase == 3) begin
				// receiver holds off while the sender keeps offering words
				tx_idle_en = 1'b0;
				long_hold  = 1'b1;
			end
			send_dumps(26);
			tx_idle_en = 1'b1;
		end

		// closing stretch with no idling on either side
		settle();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		write_base({$urandom, $urandom});
		send_dumps(30);
		settle();
		repeat (20) @(posedge clk);

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
